### hw/rtl/jsst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsst_pkg
// Shared types and constants of the job stamp synchronization table.
// ----------------------------------------------------------------------------
package jsst_pkg;

   localparam int NUM_AGENTS  = 8;
   localparam int STAMP_BITS  = 31;
   localparam int AGENT_BITS  = $clog2(NUM_AGENTS);
   localparam int MASK_BITS   = 8;
   localparam int LIVE_AGENTS = (NUM_AGENTS < MASK_BITS) ? NUM_AGENTS : MASK_BITS;
   localparam int ROW_BITS    = NUM_AGENTS * STAMP_BITS;

   localparam int FIELD_AGENT_BITS = 3;
   localparam int FIELD_STAMP_BITS = 31;
   localparam int STATUS_BITS      = 2;

   localparam logic OP_PUBLISH = 1'b0;
   localparam logic OP_WAIT    = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_DONE        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOT_REACHED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_WAITING     = 2'd2;

   typedef logic [NUM_AGENTS-1:0][STAMP_BITS-1:0] stamp_row_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/jsst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module jsst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/jsst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsst_ctrl
// Sequencer: takes a request word, runs the row update, drives the result
// handshake.
// ----------------------------------------------------------------------------
module jsst_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output jsst_pkg::ctrl_cmd_type     cmd
);
   import jsst_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign req_ready   = (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == S_EXEC) && out_free;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/jsst_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsst_datapath
// Request registers, row RAM with per-row valid bits, row compare and
// write-back, result registers.
// ----------------------------------------------------------------------------
module jsst_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire jsst_pkg::ctrl_cmd_type                  cmd,
   input  wire logic                                    req_op,
   input  wire logic [jsst_pkg::FIELD_AGENT_BITS-1:0]   req_agent_index,
   input  wire logic [jsst_pkg::FIELD_AGENT_BITS-1:0]   req_target_agent,
   input  wire logic [jsst_pkg::FIELD_STAMP_BITS-1:0]   req_job_stamp,
   input  wire logic                                    req_blocking,
   output logic      [jsst_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic      [jsst_pkg::MASK_BITS-1:0]          rsp_released_mask
);
   import jsst_pkg::*;

   logic                        op_ff;
   logic [FIELD_AGENT_BITS-1:0] me_ff;
   logic [FIELD_AGENT_BITS-1:0] tgt_ff;
   logic [STAMP_BITS-1:0]       stamp_ff;
   logic                        blk_ff;
   logic [AGENT_BITS-1:0]       row_ff;
   logic [AGENT_BITS-1:0]       rd_addr;
   logic [NUM_AGENTS-1:0]       row_valid_ff;
   logic [ROW_BITS-1:0]         ram_q;
   stamp_row_type               row_q;
   stamp_row_type               row_new;
   logic [STATUS_BITS-1:0]      status_in;
   logic [MASK_BITS-1:0]        mask_in;
   logic                        me_ok;
   logic                        tgt_ok;
   logic [STATUS_BITS-1:0]      status_ff;
   logic [MASK_BITS-1:0]        mask_ff;

   assign rd_addr = (req_op == OP_WAIT) ? req_target_agent[AGENT_BITS-1:0]
                                        : req_agent_index[AGENT_BITS-1:0];

   jsst_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(NUM_AGENTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (row_ff),
      .wr_data (row_new),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign me_ok  = (32'(me_ff)  < NUM_AGENTS);
   assign tgt_ok = (32'(tgt_ff) < NUM_AGENTS);

   always_comb begin
      row_q     = row_valid_ff[row_ff] ? stamp_row_type'(ram_q) : '0;
      row_new   = row_q;
      status_in = ST_DONE;
      mask_in   = '0;
      if (op_ff == OP_PUBLISH) begin
         if (me_ok) begin
            row_new[me_ff[AGENT_BITS-1:0]] = stamp_ff;
            for (int i = 0; i < LIVE_AGENTS; i++) begin
               if ((AGENT_BITS'(i) != me_ff[AGENT_BITS-1:0]) && (row_q[i] != '0)
                   && (row_q[i] <= stamp_ff)) begin
                  row_new[i] = '0;
                  mask_in[i] = 1'b1;
               end
            end
         end
      end else if (me_ok && tgt_ok) begin
         if (row_q[tgt_ff[AGENT_BITS-1:0]] >= stamp_ff) begin
            status_in = ST_DONE;
         end else if (!blk_ff || (me_ff == tgt_ff)) begin
            status_in = ST_NOT_REACHED;
         end else begin
            row_new[me_ff[AGENT_BITS-1:0]] = stamp_ff;
            status_in = ST_WAITING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         me_ff    <= req_agent_index;
         tgt_ff   <= req_target_agent;
         stamp_ff <= req_job_stamp[STAMP_BITS-1:0];
         blk_ff   <= req_blocking;
         row_ff   <= rd_addr;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         mask_ff   <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.commit) begin
         row_valid_ff[row_ff] <= 1'b1;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_released_mask = mask_ff;

endmodule

`default_nettype wire

### hw/rtl/job_stamp_sync_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// job_stamp_sync_table_unit
// Job stamp synchronization table for eight processing agents.
//
// Request channel (req_*): publish an agent's own stamp, or wait on another
// agent's stamp, blocking or not. Result channel (rsp_*): one word per
// request, a status code and the mask of agents a publish released.
// Each request reads its table row from the row RAM at accept; in the update
// state the row is compared (across all entries for a publish) and written
// back, which also loads the result register. No new request is taken
// until the row update is done; req_ready is low in the update state.
// rsp_valid is registered and is set together with the result register.
// When the receiver stalls, the result word holds and the block still takes
// one more request, which then waits in its update state until the result
// register frees up.
// Reset clears the per-row valid bits at once, so the whole table reads as
// zero with no clearing pass, and drops rsp_valid.
// ----------------------------------------------------------------------------
module job_stamp_sync_table_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_op,
   input  wire logic [jsst_pkg::FIELD_AGENT_BITS-1:0] req_agent_index,
   input  wire logic [jsst_pkg::FIELD_AGENT_BITS-1:0] req_target_agent,
   input  wire logic [jsst_pkg::FIELD_STAMP_BITS-1:0] req_job_stamp,
   input  wire logic                                  req_blocking,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [jsst_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic      [jsst_pkg::MASK_BITS-1:0]        rsp_released_mask
);
   import jsst_pkg::*;

   ctrl_cmd_type cmd;

   jsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   jsst_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_agent_index   (req_agent_index),
      .req_target_agent  (req_target_agent),
      .req_job_stamp     (req_job_stamp),
      .req_blocking      (req_blocking),
      .rsp_status        (rsp_status),
      .rsp_released_mask (rsp_released_mask)
   );

endmodule

`default_nettype wire

### hw/rtl/jsst_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsst_checker
// Port-level checks of the synchronization table, bound to the top level.
// ----------------------------------------------------------------------------
module jsst_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_ready,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [jsst_pkg::STATUS_BITS-1:0]      rsp_status,
   input wire logic [jsst_pkg::MASK_BITS-1:0]        rsp_released_mask
);
   import jsst_pkg::*;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken during row update");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_released_mask)))
      else $error("stalled result word changed");

   a_rsp_after_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a row update");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("reset left the block busy");

endmodule

bind job_stamp_sync_table_unit jsst_checker u_checker (.*);

`default_nettype wire
